>>> design/fwdrm_pkg.sv
// Shared constants and types of the forward running mean block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package fwdrm_pkg;

   // Default geometry of the block.
   localparam int FWDRM_MAX_WINDOW  = 32;
   localparam int FWDRM_SAMPLE_BITS = 32;

   // Window length register.
   localparam int               FWDRM_WL_BITS  = 6;
   localparam logic [6-1:0]     FWDRM_WL_RESET = 6'd1;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_OUT
   } fwdrm_state_type;

endpackage

>>> design/fwdrm_if.sv
// Word channels of the forward running mean block: sample words in, mean words out.
// Depends on fwdrm_pkg for the default sample width.
`timescale 1ns / 1ps

// Input channel: one sample word with its end-of-row mark.
interface fwdrm_req_if
   import fwdrm_pkg::*;
#(
   parameter int SAMPLE_BITS = FWDRM_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          row_end;

   modport source (output valid, output sample, output row_end, input ready);
   modport sink   (input valid, input sample, input row_end, output ready);
endinterface

// Result channel: one mean word with its last-of-row mark.
interface fwdrm_rsp_if
   import fwdrm_pkg::*;
#(
   parameter int SAMPLE_BITS = FWDRM_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] mean;
   logic                          last_of_row;

   modport source (output valid, output mean, output last_of_row, input ready);
   modport sink   (input valid, input mean, input last_of_row, output ready);
endinterface

>>> design/fwdrm_div.sv
// Bit-serial signed divider: window sum over held-sample count, truncated toward zero.
// Depends on fwdrm_pkg; used by forward_running_mean.
`timescale 1ns / 1ps

module fwdrm_div
   import fwdrm_pkg::*;
#(
   parameter int SAMPLE_BITS = FWDRM_SAMPLE_BITS,
   parameter int SUM_W       = FWDRM_SAMPLE_BITS + $clog2(FWDRM_MAX_WINDOW),
   parameter int FILL_W      = $clog2(FWDRM_MAX_WINDOW + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_W-1:0]       dividend,
   input  logic [FILL_W-1:0]             divisor,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff;
   logic [FILL_W-1:0] rem_ff;
   logic [FILL_W-1:0] div_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;

   logic [FILL_W:0]   shift_rem;
   logic              fits;
   logic [FILL_W:0]   diff_rem;
   logic [SAMPLE_BITS-1:0] mag;

   // One quotient bit per cycle, most significant first.
   assign shift_rem = {rem_ff, quo_ff[SUM_W-1]};
   assign fits      = (shift_rem >= {1'b0, div_ff});
   assign diff_rem  = shift_rem - {1'b0, div_ff};

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CNT_W'(SUM_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath: magnitude of the dividend shifts out while quotient bits shift in.
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         quo_ff <= dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(dividend)) : SUM_W'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff_rem[FILL_W-1:0] : shift_rem[FILL_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   // The mean always fits the sample width; restore the sign.
   assign mag      = quo_ff[SAMPLE_BITS-1:0];
   assign quotient = neg_ff ? signed'(SAMPLE_BITS'(0) - mag) : signed'(mag);
   assign done     = done_ff;

endmodule

>>> design/forward_running_mean.sv
// Forward running mean along a row: top level with sample ring memory and sequencer.
// Depends on fwdrm_pkg, fwdrm_req_if, fwdrm_rsp_if and fwdrm_div.
//
//   Channel   Direction  Word
//   req_ch    in         sample, row_end
//   rsp_ch    out        mean, last_of_row
//   csr_*     in         window_length (write only)
//
// A sample word is taken when the block is idle. Each mean then passes through the
// ring read, the bit-serial divider and the output load. A sample that completes no
// window returns to idle through the check state.
// A row end flushes all held samples, one mean per held sample, before the next word.
// Reset is synchronous and leaves the ring contents as they are; only entries written
// in the current row are ever read. A stalled result waits in the output register.
`timescale 1ns / 1ps

module forward_running_mean
   import fwdrm_pkg::*;
#(
   parameter int MAX_WINDOW  = FWDRM_MAX_WINDOW,
   parameter int SAMPLE_BITS = FWDRM_SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   fwdrm_req_if.sink                req_ch,
   fwdrm_rsp_if.source              rsp_ch,
   input  logic                     csr_wr_en,
   input  logic [FWDRM_WL_BITS-1:0] csr_wr_data
);

   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int IDX_W  = FILL_W + 1;

   fwdrm_state_type state_ff, state_in;

   logic [FWDRM_WL_BITS-1:0]      wl_ff;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [FILL_W-1:0]             need_ff, need_in;
   logic                          end_ff, end_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic                          last_ff, last_in;
   logic [SAMPLE_BITS-1:0]        ring_rd_ff;

   logic [SAMPLE_BITS-1:0]        ring_mem [MAX_WINDOW];

   logic                          req_ready;
   logic                          rd_en;
   logic                          div_start;
   logic                          div_done;
   logic signed [SAMPLE_BITS-1:0] div_quotient;
   logic [FILL_W-1:0]             eff_len;
   logic [IDX_W-1:0]              oldest_raw;
   logic [PTR_W-1:0]              oldest;
   logic signed [SUM_W-1:0]       sample_ext;
   logic signed [SUM_W-1:0]       drop_ext;

   // Window length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= FWDRM_WL_RESET;
      end else if (csr_wr_en) begin
         wl_ff <= csr_wr_data;
      end
   end

   // Zero acts as one; lengths past the ring act as the ring size.
   always_comb begin
      if (wl_ff == '0) begin
         eff_len = FILL_W'(1);
      end else if ({1'b0, wl_ff} > (FWDRM_WL_BITS + 1)'(MAX_WINDOW)) begin
         eff_len = FILL_W'(MAX_WINDOW);
      end else begin
         eff_len = FILL_W'(wl_ff);
      end
   end

   // Ring slot of the oldest held sample.
   always_comb begin
      oldest_raw = IDX_W'(ptr_ff) + IDX_W'(MAX_WINDOW) - IDX_W'(fill_ff);
      if (oldest_raw >= IDX_W'(MAX_WINDOW)) begin
         oldest_raw = oldest_raw - IDX_W'(MAX_WINDOW);
      end
      oldest = oldest_raw[PTR_W-1:0];
   end

   assign sample_ext = {{(SUM_W - SAMPLE_BITS){req_ch.sample[SAMPLE_BITS-1]}}, req_ch.sample};
   assign drop_ext   = {{(SUM_W - SAMPLE_BITS){ring_rd_ff[SAMPLE_BITS-1]}}, ring_rd_ff};

   // Sample ring: written on accept, read once per mean with a registered port.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ready) begin
         ring_mem[ptr_ff] <= req_ch.sample;
      end
      if (rd_en) begin
         ring_rd_ff <= ring_mem[oldest];
      end
   end

   fwdrm_div #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .FILL_W      (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer: push, then one mean per pass while enough samples are held.
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      need_in      = need_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff;
      mean_in      = mean_ff;
      last_in      = last_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               sum_in  = sum_ff + sample_ext;
               fill_in = (fill_ff == FILL_W'(MAX_WINDOW)) ? fill_ff : fill_ff + FILL_W'(1);
               ptr_in  = (ptr_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
               end_in  = req_ch.row_end;
               need_in = req_ch.row_end ? FILL_W'(1) : eff_len;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((fill_ff >= need_ff) && (fill_ff != '0)) begin
               div_start = 1'b1;
               rd_en     = 1'b1;
               state_in  = ST_DIV;
            end else begin
               if (end_ff) begin
                  sum_in  = '0;
                  fill_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               mean_in      = div_quotient;
               last_in      = end_ff && (fill_ff == FILL_W'(1));
               sum_in       = sum_ff - drop_ext;
               fill_in      = fill_ff - FILL_W'(1);
               state_in     = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         need_ff      <= FILL_W'(1);
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         need_ff      <= need_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
      last_ff <= last_in;
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.mean        = mean_ff;
   assign rsp_ch.last_of_row = last_ff;

endmodule

>>> design/fwdrm_check.sv
// Port-level checks of forward_running_mean, attached by a bind statement.
// Depends on fwdrm_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps

module fwdrm_check
   import fwdrm_pkg::*;
#(
   parameter int SAMPLE_BITS = FWDRM_SAMPLE_BITS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_mean,
   input logic                   rsp_last
);

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean) && $stable(rsp_last))
      else $error("stalled result word changed");

   // After taking a sample the block is busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("sample accepted without a processing cycle");

   // A fresh mean never appears while the block is idle and accepting samples.
   a_mean_not_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("new result word while accepting samples");

endmodule

bind forward_running_mean fwdrm_check #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_fwdrm_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_mean  (rsp_ch.mean),
   .rsp_last  (rsp_ch.last_of_row)
);
